// ===== hdl/ray_sphere_intersection_unit_macros.svh =====
//------------------------------------------------------------------------------
// Ray-sphere intersection unit assertion macros
// Shared concurrent assertion forms used by the intersection unit.
//------------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECTION_UNIT_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define RSI_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsi assertion failed");

// Expression holds at every clock edge outside reset.
`define RSI_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rsi assertion failed");

`endif

// ===== hdl/rsi_pkg.sv =====
//------------------------------------------------------------------------------
// Ray-sphere intersection package
// Widths, constants and beat types shared by the intersection pipeline.
//------------------------------------------------------------------------------
package rsi_pkg;

	localparam int CB   = 16;
	localparam int RADW = CB - 1;
	localparam int OCW  = CB + 1;
	localparam int AW   = 2 * CB;
	localparam int HW   = 2 * CB + 3;
	localparam int CW   = 2 * CB + 3;
	localparam int HMW  = 2 * CB + 2;
	localparam int DW   = 4 * CB + 6;
	localparam int SW   = DW / 2;
	localparam int RW   = SW + 2;
	localparam int NGW  = 2 * CB + 5;
	localparam int MW   = 2 * CB + 4;
	localparam int FRAC = 16;
	localparam int NW   = MW + FRAC;
	localparam int TW   = 32;
	localparam int LAT  = 5 + SW + 1 + NW + 1;

	localparam logic [TW-1:0] T_MISS  = 32'hFFFF0000;
	localparam logic [NW-1:0] Q_NEGSAT = NW'(64'h80000000);
	localparam logic [NW-1:0] Q_POSSAT = NW'(64'h7FFFFFFF);

	typedef struct packed {
		logic signed [CB-1:0] origin_x;
		logic signed [CB-1:0] origin_y;
		logic signed [CB-1:0] origin_z;
		logic signed [CB-1:0] dir_x;
		logic signed [CB-1:0] dir_y;
		logic signed [CB-1:0] dir_z;
		logic signed [CB-1:0] center_x;
		logic signed [CB-1:0] center_y;
		logic signed [CB-1:0] center_z;
		logic [RADW-1:0]      sphere_radius;
	} rsi_in_t;

	typedef struct packed {
		logic                 hit;
		logic signed [TW-1:0] distance_t;
		logic                 degenerate;
	} rsi_out_t;

	typedef struct packed {
		logic                 valid;
		logic                 miss;
		logic                 deg;
		logic [AW-1:0]        a;
		logic signed [HW-1:0] h;
		logic [DW-1:0]        d;
		logic [RW-1:0]        rem;
		logic [SW-1:0]        root;
	} rsi_sq_t;

	typedef struct packed {
		logic          valid;
		logic          miss;
		logic          deg;
		logic          neg;
		logic [AW-1:0] a;
		logic [NW-1:0] n;
		logic [AW:0]   rem;
		logic [NW-1:0] q;
	} rsi_dv_t;

endpackage

// ===== hdl/rsi_front.sv =====
//------------------------------------------------------------------------------
// Ray-sphere front end
// Five stages that form a, h, c and the discriminant of the quadratic.
//------------------------------------------------------------------------------
module rsi_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rsi_pkg::rsi_in_t ray,
	output rsi_pkg::rsi_sq_t sq
);
	import rsi_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [OCW-1:0] ocx_s1, ocy_s1, ocz_s1;
	logic signed [CB-1:0]  dx_s1, dy_s1, dz_s1;
	logic [RADW-1:0]       rad_s1;

	logic signed [2*CB-1:0]   ddx_s2, ddy_s2, ddz_s2;
	logic signed [2*CB:0]     ocdx_s2, ocdy_s2, ocdz_s2;
	logic signed [2*CB+1:0]   ococx_s2, ococy_s2, ococz_s2;
	logic [2*RADW-1:0]        rr_s2;

	logic [AW-1:0]        a_s3;
	logic signed [HW-1:0] h_s3;
	logic signed [CW-1:0] c_s3;

	logic [AW-1:0]        a_s4;
	logic signed [HW-1:0] h_s4;
	logic                 cneg_s4;
	logic [2*HMW-1:0]     hsq_s4;
	logic [AW+HMW-1:0]    ac_s4;

	logic [HMW-1:0]  hm, cm;
	logic [HMW+1:0]  ocsq;
	logic [DW-1:0]   hsq_w, ac_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign ocsq = (HMW+2)'(unsigned'(ococx_s2)) + (HMW+2)'(unsigned'(ococy_s2))
		+ (HMW+2)'(unsigned'(ococz_s2));
	assign hm = h_s3[HW-1] ? HMW'(-h_s3) : HMW'(h_s3);
	assign cm = c_s3[CW-1] ? HMW'(-c_s3) : HMW'(c_s3);
	assign hsq_w = DW'(hsq_s4);
	assign ac_w  = DW'(ac_s4);

	always_ff @(posedge clk) begin
		ocx_s1 <= OCW'(ray.origin_x) - OCW'(ray.center_x);
		ocy_s1 <= OCW'(ray.origin_y) - OCW'(ray.center_y);
		ocz_s1 <= OCW'(ray.origin_z) - OCW'(ray.center_z);
		dx_s1  <= ray.dir_x;
		dy_s1  <= ray.dir_y;
		dz_s1  <= ray.dir_z;
		rad_s1 <= ray.sphere_radius;

		ddx_s2   <= dx_s1 * dx_s1;
		ddy_s2   <= dy_s1 * dy_s1;
		ddz_s2   <= dz_s1 * dz_s1;
		ocdx_s2  <= ocx_s1 * (2*CB+1)'(dx_s1);
		ocdy_s2  <= ocy_s1 * (2*CB+1)'(dy_s1);
		ocdz_s2  <= ocz_s1 * (2*CB+1)'(dz_s1);
		ococx_s2 <= (2*CB+2)'(ocx_s1) * (2*CB+2)'(ocx_s1);
		ococy_s2 <= (2*CB+2)'(ocy_s1) * (2*CB+2)'(ocy_s1);
		ococz_s2 <= (2*CB+2)'(ocz_s1) * (2*CB+2)'(ocz_s1);
		rr_s2    <= (2*RADW)'(rad_s1) * (2*RADW)'(rad_s1);

		a_s3 <= AW'(unsigned'(ddx_s2)) + AW'(unsigned'(ddy_s2)) + AW'(unsigned'(ddz_s2));
		h_s3 <= HW'(ocdx_s2) + HW'(ocdy_s2) + HW'(ocdz_s2);
		c_s3 <= signed'(CW'(ocsq)) - signed'(CW'(rr_s2));

		a_s4    <= a_s3;
		h_s4    <= h_s3;
		cneg_s4 <= c_s3[CW-1];
		hsq_s4  <= hm * hm;
		ac_s4   <= (AW+HMW)'(a_s3) * (AW+HMW)'(cm);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq <= '0;
		end else begin
			sq.valid <= v_s4;
			sq.deg   <= (a_s4 == '0);
			sq.a     <= a_s4;
			sq.h     <= h_s4;
			sq.rem   <= '0;
			sq.root  <= '0;
			if (cneg_s4) begin
				sq.miss <= 1'b0;
				sq.d    <= hsq_w + ac_w;
			end else begin
				sq.miss <= (hsq_w < ac_w);
				sq.d    <= hsq_w - ac_w;
			end
		end
	end

endmodule

// ===== hdl/rsi_sqrt_cell.sv =====
//------------------------------------------------------------------------------
// Square root cell
// Resolves one bit of the floor square root of the discriminant.
//------------------------------------------------------------------------------
module rsi_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  rsi_pkg::rsi_sq_t sq_in,
	output rsi_pkg::rsi_sq_t sq_out
);
	import rsi_pkg::*;

	logic [RW-1:0] rem2, trial;
	logic          ge;

	assign rem2  = {sq_in.rem[RW-3:0], sq_in.d[DW-1 -: 2]};
	assign trial = {sq_in.root, 2'b01};
	assign ge    = (rem2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_out <= '0;
		end else begin
			sq_out.valid <= sq_in.valid;
			sq_out.miss  <= sq_in.miss;
			sq_out.deg   <= sq_in.deg;
			sq_out.a     <= sq_in.a;
			sq_out.h     <= sq_in.h;
			sq_out.d     <= {sq_in.d[DW-3:0], 2'b00};
			sq_out.rem   <= ge ? rem2 - trial : rem2;
			sq_out.root  <= {sq_in.root[SW-2:0], ge};
		end
	end

endmodule

// ===== hdl/rsi_div_cell.sv =====
//------------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit of the shifted numerator over a.
//------------------------------------------------------------------------------
module rsi_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  rsi_pkg::rsi_dv_t dv_in,
	output rsi_pkg::rsi_dv_t dv_out
);
	import rsi_pkg::*;

	logic [AW:0] rem2, den;
	logic        ge;

	assign rem2 = {dv_in.rem[AW-1:0], dv_in.n[NW-1]};
	assign den  = {1'b0, dv_in.a};
	assign ge   = (rem2 >= den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_out <= '0;
		end else begin
			dv_out.valid <= dv_in.valid;
			dv_out.miss  <= dv_in.miss;
			dv_out.deg   <= dv_in.deg;
			dv_out.neg   <= dv_in.neg;
			dv_out.a     <= dv_in.a;
			dv_out.n     <= {dv_in.n[NW-2:0], 1'b0};
			dv_out.rem   <= ge ? rem2 - den : rem2;
			dv_out.q     <= {dv_in.q[NW-2:0], ge};
		end
	end

endmodule

// ===== hdl/ray_sphere_intersection_unit.sv =====
//------------------------------------------------------------------------------
// Ray-sphere intersection unit
// Nearer root of the ray-sphere quadratic in Q16.16, fully pipelined.
//------------------------------------------------------------------------------
// The unit takes one ray and sphere beat in every cycle and never raises busy.
// Each result appears on result with done high for one cycle, after its beat has
// passed five front-end stages, one cell per bit of the 35-bit square root, one
// join stage, one cell per bit of the 52-bit quotient and one output register.
// The receiver must take every result as it comes.
module ray_sphere_intersection_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rsi_pkg::rsi_in_t  ray,
	output logic              done,
	output rsi_pkg::rsi_out_t result
);
	import rsi_pkg::*;
	`include "ray_sphere_intersection_unit_macros.svh"

	rsi_sq_t sq_chain [SW+1];
	rsi_dv_t dv_chain [NW+1];

	logic signed [NGW-1:0] negnum;
	logic [NW-1:0]         qsat;
	logic                  done_q;
	rsi_out_t              result_q;

	assign busy = 1'b0;

	rsi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.ray      (ray),
		.sq       (sq_chain[0])
	);

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		rsi_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.sq_in  (sq_chain[i]),
			.sq_out (sq_chain[i+1])
		);
	end

	assign negnum = NGW'(sq_chain[SW].h) + signed'(NGW'(sq_chain[SW].root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_chain[0] <= '0;
		end else begin
			dv_chain[0].valid <= sq_chain[SW].valid;
			dv_chain[0].miss  <= sq_chain[SW].miss;
			dv_chain[0].deg   <= sq_chain[SW].deg;
			dv_chain[0].neg   <= (negnum > 0);
			dv_chain[0].a     <= sq_chain[SW].a;
			dv_chain[0].n     <= {(negnum[NGW-1] ? MW'(-negnum) : MW'(negnum)), FRAC'(0)};
			dv_chain[0].rem   <= '0;
			dv_chain[0].q     <= '0;
		end
	end

	for (genvar j = 0; j < NW; j++) begin : g_div
		rsi_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.dv_in  (dv_chain[j]),
			.dv_out (dv_chain[j+1])
		);
	end

	always_comb begin
		if (dv_chain[NW].neg) begin
			qsat = (dv_chain[NW].q > Q_NEGSAT) ? Q_NEGSAT : dv_chain[NW].q;
		end else begin
			qsat = (dv_chain[NW].q > Q_POSSAT) ? Q_POSSAT : dv_chain[NW].q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_chain[NW].valid;
		end
	end

	always_ff @(posedge clk) begin
		priority if (dv_chain[NW].deg) begin
			result_q.hit        <= 1'b0;
			result_q.distance_t <= T_MISS;
			result_q.degenerate <= 1'b1;
		end else if (dv_chain[NW].miss) begin
			result_q.hit        <= 1'b0;
			result_q.distance_t <= T_MISS;
			result_q.degenerate <= 1'b0;
		end else begin
			result_q.hit        <= 1'b1;
			result_q.distance_t <= dv_chain[NW].neg ? -TW'(qsat) : TW'(qsat);
			result_q.degenerate <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`RSI_ASSERT_IMPLIES(a_miss_value, done && !result.hit, result.distance_t == T_MISS)
	`RSI_ASSERT_IMPLIES(a_deg_no_hit, done && result.degenerate, !result.hit)
	`RSI_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule
